@@ src/wrtdc_pkg.sv @@
package wrtdc_pkg;

    // result kinds carried on the master tuser
    localparam logic [1:0] ACT_ROTATE   = 2'd0;
    localparam logic [1:0] ACT_STRAIGHT = 2'd1;
    localparam logic [1:0] ACT_ARRIVED  = 2'd2;
    localparam logic [1:0] ACT_STORED   = 2'd3;

    // request kinds carried on the slave tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_POSE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_LIMIT = 3'd5;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [14:0] ANGLE_TOL_RST = 15'd2048;
    localparam logic [22:0] DIST_TOL_RST  = 23'd2048;
    localparam logic [15:0] LIN_GAIN_RST  = 16'd410;
    localparam logic [15:0] ANG_GAIN_RST  = 16'd819;
    localparam logic [14:0] ANG_LIMIT_RST = 15'd1843;
    localparam logic [14:0] LIN_LIMIT_RST = 15'd3686;

    // field widths fixed by the interface
    localparam int HEADING_W = 15;
    localparam int SPEED_W   = 15;
    localparam int TURN_W    = 16;
    localparam int ACTION_W  = 2;
    localparam int GIDX_W    = 6;
    localparam int OUT_BITS  = SPEED_W + TURN_W + GIDX_W;
    localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8;

    // iterative unit sizes
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int STEP_W       = 5;
    localparam int ZW           = 34;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;

    typedef struct packed {
        logic              capture;
        logic              diff;
        logic              init;
        logic              sum;
        logic              iter;
        logic [STEP_W-1:0] step;
        logic              round;
        logic              decide;
        logic              mul;
        logic              finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    // truncated Q30 arctangent of 2^-i
    function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/wrtdc_ctrl.sv @@
module wrtdc_ctrl
    import wrtdc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_kind,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIFF   = 4'd1;
    localparam logic [3:0] ST_INIT   = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_ITER   = 4'd4;
    localparam logic [3:0] ST_ROUND  = 4'd5;
    localparam logic [3:0] ST_DECIDE = 4'd6;
    localparam logic [3:0] ST_MUL    = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_kind == REQ_POSE) ? ST_DIFF : ST_FIN;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ src/wrtdc_datapath.sv @@
module wrtdc_datapath
    import wrtdc_pkg::*;
#(
    parameter int MAX_WAYPOINTS  = 64,
    parameter int POSITION_WIDTH = 24,
    parameter int FRACTION_BITS  = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    input  logic                         in_kind,
    input  logic signed [POSITION_WIDTH-1:0] in_x,
    input  logic signed [POSITION_WIDTH-1:0] in_y,
    input  logic signed [HEADING_W-1:0]  in_heading,
    input  logic                         in_new_path,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_idx,
    input  logic [CFG_DATA_W-1:0]        cfg_val,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [OUT_TW-1:0]            out_data,
    output logic [ACTION_W-1:0]          out_kind
);

    localparam int PW    = POSITION_WIDTH;
    localparam int AW    = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int GW    = (AW > GIDX_W) ? AW : GIDX_W;
    localparam int DW    = PW + 1;
    localparam int CW    = DW + 22;
    localparam int ANGW  = FRACTION_BITS + 10;
    localparam int APW   = 16 + ANGW + 1;
    localparam int LPW   = 16 + 32 + 1;
    localparam logic [ZW-1:0] RND_HALF = ZW'(64'd1 << (29 - FRACTION_BITS));
    localparam logic [63:0] TWO_PI_W =
        (Q30_TWO_PI + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
    localparam logic signed [ANGW-1:0] TWO_PI = ANGW'(TWO_PI_W);
    localparam logic [AW:0] MAX_LEN = (AW + 1)'(MAX_WAYPOINTS);

    // configuration registers
    logic [14:0] angle_tol_reg, ang_limit_reg, lin_limit_reg;
    logic [22:0] dist_tol_reg;
    logic [15:0] lin_gain_reg, ang_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_tol_reg <= ANGLE_TOL_RST;
            dist_tol_reg  <= DIST_TOL_RST;
            lin_gain_reg  <= LIN_GAIN_RST;
            ang_gain_reg  <= ANG_GAIN_RST;
            ang_limit_reg <= ANG_LIMIT_RST;
            lin_limit_reg <= LIN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ANGLE_TOL: angle_tol_reg <= cfg_val[14:0];
                CFG_DIST_TOL:  dist_tol_reg  <= cfg_val[22:0];
                CFG_LIN_GAIN:  lin_gain_reg  <= cfg_val[15:0];
                CFG_ANG_GAIN:  ang_gain_reg  <= cfg_val[15:0];
                CFG_ANG_LIMIT: ang_limit_reg <= cfg_val[14:0];
                CFG_LIN_LIMIT: lin_limit_reg <= cfg_val[14:0];
                default: ;
            endcase
        end
    end

    // captured request
    logic                    kind_reg, np_reg;
    logic signed [PW-1:0]    px_reg, py_reg;
    logic signed [HEADING_W-1:0] hd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            px_reg   <= in_x;
            py_reg   <= in_y;
            hd_reg   <= in_heading;
            np_reg   <= in_new_path;
        end
    end

    // path state
    logic [AW:0]          len_reg;
    logic [AW-1:0]        tgt_reg;
    logic signed [PW-1:0] gx_reg, gy_reg;

    // waypoint memory, one row holds x in the low half
    logic [2*PW-1:0] wp_mem [MAX_WAYPOINTS];
    logic [2*PW-1:0] rd_reg;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            restart;

    assign restart = np_reg || (len_reg == '0);
    assign wr_en   = cmd.finish && (kind_reg == REQ_LOAD) && (restart || (len_reg < MAX_LEN));
    assign wr_addr = restart ? '0 : len_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wp_mem[wr_addr] <= {py_reg, px_reg};
        end
        if (cmd.diff)
        begin
            rd_reg <= wp_mem[tgt_reg + 1'b1];
        end
    end

    // differences to the goal
    logic signed [DW-1:0] dx_reg, dy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dx_reg <= DW'(gx_reg) - DW'(px_reg);
            dy_reg <= DW'(gy_reg) - DW'(py_reg);
        end
    end

    // cordic start and squares
    logic signed [CW-1:0] xs, ys;
    logic [DW-1:0]        adx, ady;
    logic [63:0]          adx64, ady64;
    logic [31:0]          ax, ay;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic                 zero_reg;
    logic [63:0]          sqx_reg, sqy_reg;

    always_comb
    begin
        xs    = CW'(dx_reg) <<< 20;
        ys    = CW'(dy_reg) <<< 20;
        adx   = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ady   = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        adx64 = 64'(adx);
        ady64 = 64'(ady);
        ax    = (adx64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : adx64[31:0];
        ay    = (ady64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ady64[31:0];
    end

    // square root operand
    logic [64:0] sq_sum;
    logic [63:0] sv_reg, sr_reg;
    logic [63:0] sbit, strial;

    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign sbit   = 64'd1 << (7'd62 - {1'b0, cmd.step, 1'b0});
    assign strial = sr_reg + sbit;

    // one cordic rotation
    logic signed [CW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] atan_z;

    assign sh_x   = cx_reg >>> cmd.step;
    assign sh_y   = cy_reg >>> cmd.step;
    assign atan_z = ZW'(atan_q30(cmd.step));

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            zero_reg <= (dx_reg == '0) && (dy_reg == '0);
            sqx_reg  <= ax * ax;
            sqy_reg  <= ay * ay;
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    cx_reg <= ys;
                    cy_reg <= -xs;
                    cz_reg <= Q30_HALF_PI;
                end
                else
                begin
                    cx_reg <= -ys;
                    cy_reg <= xs;
                    cz_reg <= -Q30_HALF_PI;
                end
            end
            else
            begin
                cx_reg <= xs;
                cy_reg <= ys;
                cz_reg <= '0;
            end
        end
        else if (cmd.iter && (cmd.step < STEP_W'(CORDIC_STEPS)))
        begin
            if (cy_reg >= 0)
            begin
                cx_reg <= cx_reg + sh_y;
                cy_reg <= cy_reg - sh_x;
                cz_reg <= cz_reg + atan_z;
            end
            else
            begin
                cx_reg <= cx_reg - sh_y;
                cy_reg <= cy_reg + sh_x;
                cz_reg <= cz_reg - atan_z;
            end
        end
    end

    // bit-pair square root, one result bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sv_reg <= sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
            sr_reg <= '0;
        end
        else if (cmd.iter)
        begin
            if (sv_reg >= strial)
            begin
                sv_reg <= sv_reg - strial;
                sr_reg <= (sr_reg >> 1) + sbit;
            end
            else
            begin
                sr_reg <= sr_reg >> 1;
            end
        end
    end

    // bearing rounding and yaw wrap
    logic [ZW-1:0]          zmag, zrnd;
    logic signed [ANGW-1:0] brg_reg, yaw_reg, hd_ext;

    assign zmag   = cz_reg[ZW-1] ? ZW'(-cz_reg) : ZW'(cz_reg);
    assign zrnd   = (zmag + RND_HALF) >> (30 - FRACTION_BITS);
    assign hd_ext = ANGW'(hd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            if (zero_reg)
            begin
                brg_reg <= '0;
            end
            else
            begin
                brg_reg <= cz_reg[ZW-1] ? -ANGW'(zrnd) : ANGW'(zrnd);
            end
            yaw_reg <= (hd_reg < 0) ? hd_ext + TWO_PI : hd_ext;
        end
    end

    // turn direction, error and mode
    logic signed [ANGW-1:0] ediff, wrap_a, wrap_b;
    logic [ANGW-1:0]        err_reg;
    logic                   dir_neg_reg, rot_reg, near_reg;
    logic [31:0]            dist_reg;

    assign ediff  = yaw_reg - brg_reg;
    assign wrap_a = TWO_PI - yaw_reg + brg_reg;
    assign wrap_b = TWO_PI - brg_reg + yaw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            if (brg_reg < yaw_reg)
            begin
                dir_neg_reg <= !(wrap_a < ediff);
            end
            else
            begin
                dir_neg_reg <= wrap_b < -ediff;
            end
            err_reg  <= ediff[ANGW-1] ? ANGW'(-ediff) : ANGW'(ediff);
            rot_reg  <= (ediff[ANGW-1] ? ANGW'(-ediff) : ANGW'(ediff)) > ANGW'(angle_tol_reg);
            dist_reg <= sr_reg[31:0];
            near_reg <= sr_reg[31:0] < 32'(dist_tol_reg);
        end
    end

    // gain products with rounding half
    logic [APW-1:0] aprod_reg;
    logic [LPW-1:0] lprod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            aprod_reg <= APW'(ang_gain_reg) * APW'(err_reg) + APW'(1 << (FRACTION_BITS - 1));
            lprod_reg <= LPW'(lin_gain_reg) * LPW'(dist_reg) + LPW'(1 << (FRACTION_BITS - 1));
        end
    end

    // capped speeds
    logic [APW-1:0]     amag;
    logic [LPW-1:0]     lmag;
    logic [SPEED_W-1:0] acap, lcap;
    logic [TURN_W-1:0]  turn;

    assign amag = aprod_reg >> FRACTION_BITS;
    assign lmag = lprod_reg >> FRACTION_BITS;
    assign acap = (amag > APW'(ang_limit_reg)) ? ang_limit_reg : amag[SPEED_W-1:0];
    assign lcap = (lmag > LPW'(lin_limit_reg)) ? lin_limit_reg : lmag[SPEED_W-1:0];
    assign turn = dir_neg_reg ? TURN_W'(-{1'b0, acap}) : {1'b0, acap};

    // result and path update
    logic [1:0]         act;
    logic [AW-1:0]      tgt_new;
    logic [GW-1:0]      tgt_wide;
    logic [SPEED_W-1:0] fwd_o;
    logic [TURN_W-1:0]  turn_o;
    logic               advance;

    always_comb
    begin
        advance = 1'b0;
        fwd_o   = '0;
        turn_o  = '0;
        tgt_new = tgt_reg;
        if (kind_reg == REQ_LOAD)
        begin
            act = ACT_STORED;
            if (restart)
            begin
                tgt_new = '0;
            end
        end
        else if (rot_reg)
        begin
            act    = ACT_ROTATE;
            turn_o = turn;
        end
        else if (!near_reg)
        begin
            act   = ACT_STRAIGHT;
            fwd_o = lcap;
        end
        else
        begin
            act = ACT_ARRIVED;
            if ((AW + 1)'(tgt_reg) + 1'b1 < len_reg)
            begin
                advance = 1'b1;
                tgt_new = tgt_reg + 1'b1;
            end
        end
        tgt_wide = GW'(tgt_new);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            tgt_reg <= '0;
            gx_reg  <= '0;
            gy_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            tgt_reg <= tgt_new;
            if (kind_reg == REQ_LOAD)
            begin
                if (restart)
                begin
                    len_reg <= (AW + 1)'(1);
                    gx_reg  <= px_reg;
                    gy_reg  <= py_reg;
                end
                else if (len_reg < MAX_LEN)
                begin
                    len_reg <= len_reg + 1'b1;
                end
            end
            else if (advance)
            begin
                gx_reg <= rd_reg[PW-1:0];
                gy_reg <= rd_reg[2*PW-1:PW];
            end
        end
    end

    // output register
    logic                out_valid_reg;
    logic [OUT_TW-1:0]   out_data_reg;
    logic [ACTION_W-1:0] out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= OUT_TW'({tgt_wide[GIDX_W-1:0], turn_o, fwd_o});
            out_kind_reg <= act;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign out_kind     = out_kind_reg;

endmodule

@@ src/waypoint_rotate_then_drive_controller_core.sv @@
// Waypoint follower, rotate then drive.
// Slave channel (s_*): one transfer per request. s_tuser is the request kind:
// load a waypoint or a pose tick. Loads append to the list, or restart it when
// new_path is set or the list is empty.
// Master channel (m_*): exactly one result transfer per request, in order;
// m_tuser is the action (rotate, straight, arrived, stored).
// Config channel (cfg_*): register index and data, always ready; write only
// while no request is in flight.
// Sequence: a load goes from acceptance straight to the finish state, a pose tick
// first through diff, init, sum, iteration, round, decide and mul; finish waits
// for a free output register, then the next request is taken in idle. The shared
// iteration runs 32 square-root steps; the cordic uses the first CORDIC_STEPS.
// One request is in flight at a time; a stalled result waits in the output
// register, the next request is still taken and computed, then holds the
// block until the stalled result is taken.
// Reset clears the path: no waypoints, goal at the origin, registers to
// defaults. The waypoint memory itself is not cleared.
module waypoint_rotate_then_drive_controller_core
    import wrtdc_pkg::*;
#(
    parameter int MAX_WAYPOINTS  = 64,
    parameter int POSITION_WIDTH = 24,
    parameter int FRACTION_BITS  = 12,
    localparam int IN_TW         = ((2 * POSITION_WIDTH + HEADING_W + 1 + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_x, point_y, heading, new_path, zero fill
    input  logic [IN_TW-1:0]      s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // forward_speed, turn_rate, goal_index, zero fill
    output logic [OUT_TW-1:0]     m_tdata,
    // action
    output logic [ACTION_W-1:0]   m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = POSITION_WIDTH;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    wrtdc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wrtdc_datapath
    #(
        .MAX_WAYPOINTS  (MAX_WAYPOINTS),
        .POSITION_WIDTH (POSITION_WIDTH),
        .FRACTION_BITS  (FRACTION_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (s_tuser),
        .in_x        (s_tdata[PW-1:0]),
        .in_y        (s_tdata[2*PW-1:PW]),
        .in_heading  (s_tdata[2*PW+HEADING_W-1:2*PW]),
        .in_new_path (s_tdata[2*PW+HEADING_W]),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_val     (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_kind    (m_tuser)
    );

endmodule

@@ src/wrtdc_checker.sv @@
module wrtdc_checker
    import wrtdc_pkg::*;
#(
    parameter int IN_TW = 64
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_TW-1:0]      s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_TW-1:0]     m_tdata,
    input logic [ACTION_W-1:0]   m_tuser,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one request in flight: no back-to-back acceptance
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // rotate and stored results carry no forward speed
    a_rot_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ACT_ROTATE || m_tuser == ACT_STORED)
        |-> m_tdata[SPEED_W-1:0] == '0)
        else $error("forward speed while rotating or storing");

    // straight, arrived and stored results carry no turn
    a_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ACT_STRAIGHT || m_tuser == ACT_ARRIVED ||
        m_tuser == ACT_STORED) |-> m_tdata[SPEED_W+TURN_W-1:SPEED_W] == '0)
        else $error("turn rate outside rotation");

endmodule

bind waypoint_rotate_then_drive_controller_core wrtdc_checker #(.IN_TW(IN_TW)) u_chk (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import wrtdc_pkg::*;

    localparam int NWP    = 64;
    localparam int PW     = 24;
    localparam int FB     = 12;
    localparam int IN_TW  = ((2 * PW + HEADING_W + 1 + 7) / 8) * 8;
    localparam int LIMIT  = 1500000;

    typedef struct packed {
        logic                 kind;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [14:0]   yaw;
        logic                 restart;
    } request_t;

    typedef struct packed {
        logic [14:0]        fwd;
        logic signed [15:0] turn;
        logic [1:0]         act;
        logic [5:0]         gidx;
    } command_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TW-1:0] m_tdata;
    logic [ACTION_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    waypoint_rotate_then_drive_controller_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // controller model state
    longint wp_x [NWP];
    longint wp_y [NWP];
    int unsigned n_points;
    int unsigned target;
    longint goal_x, goal_y;
    longint unsigned tol_angle, tol_dist, gain_lin, gain_ang, lim_ang, lim_lin;

    request_t pending_requests[$];
    command_t expected_commands[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int n_rotate = 0, n_straight = 0, n_arrived = 0;
    bit hold_off = 1'b0;
    longint unsigned cycles = 0;

    function automatic longint arith_shift(longint v, int s);
        return v >>> s;
    endfunction

    // cordic bearing of goal minus robot, rounded to q12
    function automatic longint bearing_to(longint dx, longint dy);
        longint x, y, z, t, m;
        x = dx * 64'sd1048576;
        y = dy * 64'sd1048576;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 64'sd1686629713;
            end
            else
            begin
                x = -y; y = t; z = -64'sd1686629713;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            t = x;
            if (y >= 0)
            begin
                x += arith_shift(y, i); y -= arith_shift(t, i);
                z += longint'(atan_q30(5'(i)));
            end
            else
            begin
                x -= arith_shift(y, i); y += arith_shift(t, i);
                z -= longint'(atan_q30(5'(i)));
            end
        end
        m = (z < 0) ? -z : z;
        m = (m + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
        return (z < 0) ? -m : m;
    endfunction

    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b; r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned range_to(longint dx, longint dy);
        longint unsigned ax, ay, sx, sum;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > 64'hFFFFFFFF) ax = 64'hFFFFFFFF;
        if (ay > 64'hFFFFFFFF) ay = 64'hFFFFFFFF;
        sx = ax * ax;
        sum = sx + ay * ay;
        if (sum < sx)
            sum = '1;
        return root_of(sum);
    endfunction

    function automatic longint unsigned apply_gain(longint unsigned g, longint unsigned v);
        return (g * v + (64'd1 << (FB - 1))) >> FB;
    endfunction

    function automatic void reset_controller();
        n_points = 0; target = 0; goal_x = 0; goal_y = 0;
        tol_angle = ANGLE_TOL_RST; tol_dist = DIST_TOL_RST;
        gain_lin = LIN_GAIN_RST; gain_ang = ANG_GAIN_RST;
        lim_ang = ANG_LIMIT_RST; lim_lin = LIN_LIMIT_RST;
    endfunction

    function automatic command_t steer(request_t r);
        command_t c;
        longint two_pi, yaw, dx, dy, brg, err, dir;
        longint unsigned mag, d;
        c = '0;
        if (r.kind == REQ_LOAD)
        begin
            if (r.restart || n_points == 0)
            begin
                wp_x[0] = r.px; wp_y[0] = r.py;
                n_points = 1; target = 0; goal_x = r.px; goal_y = r.py;
            end
            else if (n_points < NWP)
            begin
                wp_x[n_points] = r.px; wp_y[n_points] = r.py;
                n_points++;
            end
            c.act = ACT_STORED;
        end
        else
        begin
            two_pi = longint'((Q30_TWO_PI + (64'd1 << (29 - FB))) >> (30 - FB));
            yaw = r.yaw;
            dx = goal_x - longint'(r.px);
            dy = goal_y - longint'(r.py);
            brg = bearing_to(dx, dy);
            if (yaw < 0)
                yaw += two_pi;
            if (brg < yaw)
                dir = ((two_pi - yaw + brg) < (yaw - brg)) ? 1 : -1;
            else
                dir = ((two_pi - brg + yaw) < (brg - yaw)) ? -1 : 1;
            err = yaw - brg;
            if (err < 0)
                err = -err;
            if (longint'(err) > longint'(tol_angle))
            begin
                mag = apply_gain(gain_ang, err);
                if (mag > lim_ang)
                    mag = lim_ang;
                c.turn = 16'(dir * longint'(mag));
                c.act = ACT_ROTATE;
            end
            else
            begin
                d = range_to(dx, dy);
                if (d >= tol_dist)
                begin
                    mag = apply_gain(gain_lin, d);
                    if (mag > lim_lin)
                        mag = lim_lin;
                    c.fwd = 15'(mag);
                    c.act = ACT_STRAIGHT;
                end
                else
                begin
                    if (target + 1 < n_points)
                    begin
                        target++;
                        goal_x = wp_x[target]; goal_y = wp_y[target];
                    end
                    c.act = ACT_ARRIVED;
                end
            end
        end
        c.gidx = 6'(target);
        return c;
    endfunction

    // request driver with random gaps
    int gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_commands.push_back(steer(pending_requests.pop_front()));
                sent++;
            end
            if (s_tvalid && !(s_tready))
                ;
            else if (gap > 0)
            begin
                gap <= gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                request_t r;
                r = pending_requests[0];
                s_tvalid <= 1'b1;
                s_tuser <= r.kind;
                s_tdata <= IN_TW'({r.restart, r.yaw, r.py, r.px});
                if ($urandom_range(0, 3) == 0)
                    gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                       : $urandom_range(1, 4);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result monitor with random stalls
    int stall = 0;
    always @(posedge clk)
    begin
        command_t got, exp_c;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.fwd  = m_tdata[14:0];
                got.turn = m_tdata[30:15];
                got.gidx = m_tdata[36:31];
                got.act  = m_tuser;
                received++;
                if (expected_commands.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end
                else
                begin
                    exp_c = expected_commands.pop_front();
                    case (got.act)
                        ACT_ROTATE:   n_rotate++;
                        ACT_STRAIGHT: n_straight++;
                        ACT_ARRIVED:  n_arrived++;
                        default: ;
                    endcase
                    if (got.fwd !== exp_c.fwd || got.turn !== exp_c.turn ||
                        got.act !== exp_c.act || got.gidx !== exp_c.gidx)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, exp_c, got);
                    end
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (stall > 0)
            begin
                stall <= stall - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                         : $urandom_range(1, 4);
            end
        end
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic request_t make_load(longint x, longint y, bit restart);
        request_t r;
        r.kind = REQ_LOAD; r.px = PW'(x); r.py = PW'(y);
        r.yaw = 15'($urandom); r.restart = restart;
        return r;
    endfunction

    function automatic request_t make_pose(longint x, longint y, longint yaw);
        request_t r;
        r.kind = REQ_POSE; r.px = PW'(x); r.py = PW'(y);
        r.yaw = 15'(yaw); r.restart = $urandom_range(0, 1);
        return r;
    endfunction

    task automatic drain();
        while (pending_requests.size() > 0 || expected_commands.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ANGLE_TOL: tol_angle = v & 64'h7FFF;
            CFG_DIST_TOL:  tol_dist  = v & 64'h7FFFFF;
            CFG_LIN_GAIN:  gain_lin  = v & 64'hFFFF;
            CFG_ANG_GAIN:  gain_ang  = v & 64'hFFFF;
            CFG_ANG_LIMIT: lim_ang   = v & 64'h7FFF;
            CFG_LIN_LIMIT: lim_lin   = v & 64'h7FFF;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // a path of nearby points, then pose ticks scattered around its first point
    task automatic queue_route(int len, int spread);
        longint cx, cy, rx, ry, yaw;
        cx = $signed($urandom_range(0, 2000)) - 1000;
        cy = $signed($urandom_range(0, 2000)) - 1000;
        pending_requests.push_back(make_load(cx, cy, 1'b1));
        for (int i = 1; i < len; i++)
            pending_requests.push_back(make_load(cx + $signed($urandom_range(0, 2 * spread)) - spread,
                cy + $signed($urandom_range(0, 2 * spread)) - spread, 1'b0));
        rx = cx; ry = cy;
        for (int i = 0; i < 3 * len; i++)
        begin
            yaw = $signed($urandom_range(0, 25736)) - 12868;
            if ($urandom_range(0, 2) != 0)
                yaw = 0;
            pending_requests.push_back(make_pose(rx + $signed($urandom_range(0, 2 * spread)) - spread,
                ry + $signed($urandom_range(0, 2 * spread)) - spread, yaw));
        end
    endtask

    initial
    begin
        int phase_items;
        reset_controller();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no path yet, field extremes, append past a full list
        pending_requests.push_back(make_pose(0, 0, 0));
        pending_requests.push_back(make_pose(-8388608, 8388607, 12868));
        pending_requests.push_back(make_pose(8388607, -8388608, -12868));
        pending_requests.push_back(make_pose(100, -100, 0));
        pending_requests.push_back(make_load(8388607, -8388608, 1'b0));
        pending_requests.push_back(make_pose(-8388608, 8388607, -12868));
        pending_requests.push_back(make_pose(8388607, -8388608, 0));
        pending_requests.push_back(make_load(-8388608, 8388607, 1'b1));
        pending_requests.push_back(make_pose(-8388608, 8388607, 0));
        pending_requests.push_back(make_load(0, 0, 1'b1));
        pending_requests.push_back(make_load(0, 0, 1'b0));
        pending_requests.push_back(make_pose(0, 0, 0));
        pending_requests.push_back(make_pose(0, 0, 0));
        pending_requests.push_back(make_pose(0, 0, 0));
        pending_requests.push_back(make_pose(-5000, 0, 0));
        pending_requests.push_back(make_pose(0, -5000, 12000));
        drain();
        for (int i = 0; i < 70; i++)
            pending_requests.push_back(make_load(i * 7, -i * 3, 1'b0));
        for (int i = 0; i < 70; i++)
            pending_requests.push_back(make_pose(-i * 3, i * 7, 0));
        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: ;
                1:
                begin
                    write_reg(CFG_ANGLE_TOL, 32767); write_reg(CFG_DIST_TOL, 0);
                    write_reg(CFG_LIN_GAIN, 65535); write_reg(CFG_ANG_GAIN, 65535);
                    write_reg(CFG_ANG_LIMIT, 32767); write_reg(CFG_LIN_LIMIT, 32767);
                end
                2:
                begin
                    write_reg(CFG_ANGLE_TOL, 0); write_reg(CFG_DIST_TOL, 8388607);
                    write_reg(CFG_LIN_GAIN, 0); write_reg(CFG_ANG_GAIN, 0);
                    write_reg(CFG_ANG_LIMIT, 0); write_reg(CFG_LIN_LIMIT, 0);
                end
                default:
                begin
                    write_reg(CFG_ANGLE_TOL, $urandom_range(0, 32767));
                    write_reg(CFG_DIST_TOL, $urandom_range(0, 3000));
                    write_reg(CFG_LIN_GAIN, $urandom_range(0, 65535));
                    write_reg(CFG_ANG_GAIN, $urandom_range(0, 65535));
                    write_reg(CFG_ANG_LIMIT, $urandom_range(0, 32767));
                    write_reg(CFG_LIN_LIMIT, $urandom_range(0, 32767));
                end
            endcase
            phase_items = 0;
            while (phase_items < 300)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    int len;
                    len = $urandom_range(1, 8);
                    queue_route(len, $urandom_range(0, 1) ? 600 : 8000);
                    phase_items += 4 * len;
                end
                else
                begin
                    request_t r;
                    r.kind = $urandom_range(0, 1);
                    r.px = PW'($urandom);
                    r.py = PW'($urandom);
                    r.yaw = 15'($signed($urandom_range(0, 25736)) - 12868);
                    r.restart = $urandom_range(0, 1);
                    pending_requests.push_back(r);
                    phase_items++;
                end
            end
            drain();
        end

        $display("covered %0d requests, %0d results: %0d rotate, %0d straight, %0d arrived",
                 sent, received, n_rotate, n_straight, n_arrived);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
